>>> rtl/sdcsd_pkg.sv
package sdcsd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    localparam int HIGH_W  = 64;
    localparam int MID_W   = 56;
    localparam int BUS_W   = 27;
    localparam int RATE_W  = 27;
    localparam int BLK_W   = 33;
    localparam int SIZE_W  = 16;
    localparam int WAIT_W  = 40;
    localparam int X_W     = 34;
    localparam int RECIP_W = 25;
    localparam int Q_W     = 24;
    localparam int P5_W    = 24;
    localparam int NSAC_X_W = 15;
    localparam int SUM_W   = 24;
    localparam int DIV80_W = 21;
    localparam int RD_W    = 22;
    localparam int WR_W    = 29;

    localparam int RECIP_SHIFT = 34;
    localparam int DIV80_SHIFT = 26;
    localparam logic [P5_W-1:0] DIV80_RECIP = 24'd13421773;

    localparam logic [BUS_W-1:0]  BUS_CLOCK_RESET = 27'd12000000;
    localparam logic [RATE_W-1:0] MAX_RATE_RESET  = 27'd16500000;

    localparam logic [3:0] BL_LEN_MIN = 4'd9;
    localparam logic [2:0] R2W_MAX    = 3'd5;
    localparam logic [2:0] RATE_UNIT_MAX = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUS_CLOCK = 2'd0,
        CFG_MAX_RATE  = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CSD_SD_V1    = 2'd0,
        CSD_SD_V2    = 2'd1,
        CSD_MMC      = 2'd2,
        CSD_RESERVED = 2'd3
    } csd_ver_t;

    typedef struct packed {
        logic                bad;
        logic                sd_v2;
        logic [2:0]          r2w;
        logic [3:0]          bl_len;
        logic [BLK_W-1:0]    blocks;
        logic [RATE_W-1:0]   rate;
        logic [DIV80_W-1:0]  bus_div80;
    } side_t;

    typedef struct packed {
        side_t            side;
        logic [X_W-1:0]   x;
        logic [2:0]       tu;
        logic [7:0]       nsac;
    } dec_t;

    typedef struct packed {
        side_t              side;
        logic [SUM_W-1:0]   sum;
    } wait_t;

    function automatic logic [6:0] time_value_x10(input logic [3:0] code);
        logic [6:0] v;
        unique case (code)
            4'd0:  v = 7'd0;
            4'd1:  v = 7'd10;
            4'd2:  v = 7'd12;
            4'd3:  v = 7'd13;
            4'd4:  v = 7'd15;
            4'd5:  v = 7'd20;
            4'd6:  v = 7'd25;
            4'd7:  v = 7'd30;
            4'd8:  v = 7'd35;
            4'd9:  v = 7'd40;
            4'd10: v = 7'd45;
            4'd11: v = 7'd50;
            4'd12: v = 7'd55;
            4'd13: v = 7'd60;
            4'd14: v = 7'd70;
            default: v = 7'd80;
        endcase
        return v;
    endfunction

    function automatic logic [29:0] rate_hz(input logic [3:0] rv, input logic [2:0] ru);
        logic [23:0] unit;
        unique case (ru)
            3'd0:    unit = 24'd10000;
            3'd1:    unit = 24'd100000;
            3'd2:    unit = 24'd1000000;
            3'd3:    unit = 24'd10000000;
            default: unit = 24'd0;
        endcase
        return 30'({23'd0, time_value_x10(rv)} * {6'd0, unit});
    endfunction

    function automatic logic [RECIP_W-1:0] access_recip(input logic [2:0] tu);
        logic [RECIP_W-1:0] m;
        unique case (tu)
            3'd0:    m = 25'd1;
            3'd1:    m = 25'd17;
            3'd2:    m = 25'd171;
            3'd3:    m = 25'd1717;
            3'd4:    m = 25'd17179;
            3'd5:    m = 25'd171798;
            3'd6:    m = 25'd1717986;
            default: m = 25'd17179869;
        endcase
        return m;
    endfunction

    function automatic logic [X_W-1:0] access_div(input logic [2:0] tu);
        logic [X_W-1:0] d;
        unique case (tu)
            3'd0:    d = 34'd10000000000;
            3'd1:    d = 34'd1000000000;
            3'd2:    d = 34'd100000000;
            3'd3:    d = 34'd10000000;
            3'd4:    d = 34'd1000000;
            3'd5:    d = 34'd100000;
            3'd6:    d = 34'd10000;
            default: d = 34'd1000;
        endcase
        return d;
    endfunction

    function automatic logic [P5_W-1:0] access_pow5(input logic [2:0] tu);
        logic [P5_W-1:0] p;
        unique case (tu)
            3'd0:    p = 24'd9765625;
            3'd1:    p = 24'd1953125;
            3'd2:    p = 24'd390625;
            3'd3:    p = 24'd78125;
            3'd4:    p = 24'd15625;
            3'd5:    p = 24'd3125;
            3'd6:    p = 24'd625;
            default: p = 24'd125;
        endcase
        return p;
    endfunction

    function automatic logic [3:0] access_shift(input logic [2:0] tu);
        return 4'd10 - {1'b0, tu};
    endfunction

endpackage

>>> rtl/sdcsd_ifs.sv
interface sdcsd_in_if;
    logic                              valid;
    logic                              ready;
    logic [sdcsd_pkg::HIGH_W-1:0]      csd_high;
    logic [sdcsd_pkg::MID_W-1:0]       csd_mid;

    modport source (output valid, output csd_high, output csd_mid, input ready);
    modport sink   (input valid, input csd_high, input csd_mid, output ready);
endinterface

interface sdcsd_out_if;
    logic                              valid;
    logic                              ready;
    logic                              status;
    logic [sdcsd_pkg::SIZE_W-1:0]      block_size_bytes;
    logic [sdcsd_pkg::BLK_W-1:0]       block_count;
    logic [sdcsd_pkg::WAIT_W-1:0]      read_timeout_cycles;
    logic [sdcsd_pkg::WAIT_W-1:0]      write_timeout_cycles;
    logic [sdcsd_pkg::WAIT_W-1:0]      erase_timeout_cycles;
    logic [sdcsd_pkg::RATE_W-1:0]      bit_rate_hz;

    modport source (output valid, output status, output block_size_bytes, output block_count,
                    output read_timeout_cycles, output write_timeout_cycles,
                    output erase_timeout_cycles, output bit_rate_hz, input ready);
    modport sink   (input valid, input status, input block_size_bytes, input block_count,
                    input read_timeout_cycles, input write_timeout_cycles,
                    input erase_timeout_cycles, input bit_rate_hz, output ready);
endinterface

interface sdcsd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sdcsd_pkg::CFG_IDX_W-1:0]   index;
    logic [sdcsd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/sd_csd_metrics_decoder_unit.sv
// Throughput: one word per cycle unless a stalled result holds the flow; the
// pipeline has five register stages and the widest step is the reciprocal
// multiply that divides the access time.
// A stalled result freezes every stage, so csd.ready is low only while it waits.
// Reset clears all stage valid bits and loads the bus clock and rate limit
// registers with 12000000 and 16500000.
module sd_csd_metrics_decoder_unit (
    input  logic  clk,
    input  logic  rst_n,
    sdcsd_cfg_if.sink  cfg,
    sdcsd_in_if.sink   csd,
    sdcsd_out_if.source metrics
);
    import sdcsd_pkg::*;

    localparam int STAGES = 5;

    logic [BUS_W-1:0]   bus_clock_reg;
    logic [RATE_W-1:0]  max_rate_reg;
    logic [STAGES-1:0]  valid_reg;
    logic [STAGES-1:0]  valid_next;
    logic               adv;
    dec_t               dec;
    wait_t              wt;

    logic [RD_W-1:0]    wait_n;
    logic [RD_W-1:0]    div80;
    logic [RD_W-1:0]    rd;
    logic [WR_W-1:0]    wr;

    logic               status_reg;
    logic               status_next;
    logic [SIZE_W-1:0]  size_reg;
    logic [SIZE_W-1:0]  size_next;
    logic [BLK_W-1:0]   blocks_reg;
    logic [BLK_W-1:0]   blocks_next;
    logic [WAIT_W-1:0]  rd_reg;
    logic [WAIT_W-1:0]  rd_next;
    logic [WAIT_W-1:0]  wr_reg;
    logic [WAIT_W-1:0]  wr_next;
    logic [RATE_W-1:0]  rate_reg;
    logic [RATE_W-1:0]  rate_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_clock_reg <= BUS_CLOCK_RESET;
            max_rate_reg  <= MAX_RATE_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_BUS_CLOCK)
            begin
                bus_clock_reg <= cfg.data;
            end
            if (cfg.index == CFG_MAX_RATE)
            begin
                max_rate_reg <= cfg.data;
            end
        end
    end

    assign adv        = !valid_reg[STAGES-1] || metrics.ready;
    assign csd.ready  = adv;
    assign valid_next = {valid_reg[STAGES-2:0], csd.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    sdcsd_decode u_decode (
        .clk       (clk),
        .adv       (adv),
        .bus_clock (bus_clock_reg),
        .max_rate  (max_rate_reg),
        .csd_high  (csd.csd_high),
        .csd_mid   (csd.csd_mid),
        .dec       (dec)
    );

    sdcsd_wait u_wait (
        .clk (clk),
        .adv (adv),
        .dec (dec),
        .wt  (wt)
    );

    always_comb
    begin
        wait_n = {1'b0, wt.sum[SUM_W-1:3]} + {{(RD_W-1){1'b0}}, 1'b1};
        div80  = {1'b0, wt.side.bus_div80};
        if (wt.side.sd_v2)
        begin
            rd = div80;
            wr = {7'd0, bus_clock_reg[BUS_W-1:5]};
        end
        else
        begin
            rd = (div80 > wait_n) ? div80 : wait_n;
            wr = {7'd0, rd} << wt.side.r2w;
        end

        status_next = wt.side.bad;
        if (wt.side.bad)
        begin
            size_next   = '0;
            blocks_next = '0;
            rd_next     = '0;
            wr_next     = '0;
            rate_next   = '0;
        end
        else
        begin
            size_next   = {{(SIZE_W-1){1'b0}}, 1'b1} << wt.side.bl_len;
            blocks_next = wt.side.blocks;
            rd_next     = {{(WAIT_W-RD_W){1'b0}}, rd};
            wr_next     = {{(WAIT_W-WR_W){1'b0}}, wr};
            rate_next   = wt.side.rate;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= status_next;
            size_reg   <= size_next;
            blocks_reg <= blocks_next;
            rd_reg     <= rd_next;
            wr_reg     <= wr_next;
            rate_reg   <= rate_next;
        end
    end

    assign metrics.valid                = valid_reg[STAGES-1];
    assign metrics.status               = status_reg;
    assign metrics.block_size_bytes     = size_reg;
    assign metrics.block_count          = blocks_reg;
    assign metrics.read_timeout_cycles  = rd_reg;
    assign metrics.write_timeout_cycles = wr_reg;
    assign metrics.erase_timeout_cycles = wr_reg;
    assign metrics.bit_rate_hz          = rate_reg;

`ifndef SYNTH
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (metrics.valid && !metrics.ready) |-> !csd.ready)
        else $error("input taken while result word stalled");

    a_unusable_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (metrics.valid && metrics.status) |->
            (metrics.block_count == '0 && metrics.read_timeout_cycles == '0
             && metrics.write_timeout_cycles == '0 && metrics.bit_rate_hz == '0))
        else $error("unusable card word carries nonzero metrics");

    a_write_ge_read: assert property (@(posedge clk) disable iff (!rst_n)
        (metrics.valid && !metrics.status) |->
            (metrics.write_timeout_cycles >= metrics.read_timeout_cycles))
        else $error("write wait below read wait");

    a_rate_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (metrics.valid && !metrics.status) |->
            (metrics.bit_rate_hz <= max_rate_reg && metrics.block_size_bytes >= 16'd512))
        else $error("rate above limit or block size below 512");
`endif

endmodule

>>> rtl/sdcsd_decode.sv
module sdcsd_decode (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [sdcsd_pkg::BUS_W-1:0]   bus_clock,
    input  logic [sdcsd_pkg::RATE_W-1:0]  max_rate,
    input  logic [sdcsd_pkg::HIGH_W-1:0]  csd_high,
    input  logic [sdcsd_pkg::MID_W-1:0]   csd_mid,
    output sdcsd_pkg::dec_t               dec
);
    import sdcsd_pkg::*;

    csd_ver_t          ver;
    logic [3:0]        tv;
    logic [3:0]        rv;
    logic [2:0]        ru;
    logic [3:0]        bl_len;
    logic              partial;
    logic [2:0]        r2w;
    logic [11:0]       c_size_v1;
    logic [2:0]        mult;
    logic [21:0]       c_size_v2;
    logic [4:0]        blk_shift;
    logic [29:0]       rate_raw;
    logic [46:0]       div80_prod;
    logic              bad_len;
    dec_t              dec_next;
    dec_t              dec_reg;

    always_comb
    begin
        ver       = csd_ver_t'(csd_high[63:62]);
        tv        = csd_high[54:51];
        rv        = csd_high[38:35];
        ru        = csd_high[34:32];
        bl_len    = csd_high[19:16];
        partial   = csd_high[15];
        r2w       = csd_mid[20:18];
        c_size_v1 = {csd_high[9:0], csd_mid[55:54]};
        mult      = csd_mid[41:39];
        c_size_v2 = {csd_high[5:0], csd_mid[55:40]};

        bad_len = (bl_len < BL_LEN_MIN) || ((bl_len > BL_LEN_MIN) && !partial);

        dec_next.side.bad = bad_len || (ver == CSD_RESERVED)
                          || ((ver == CSD_SD_V1) && (r2w > R2W_MAX))
                          || (ru > RATE_UNIT_MAX);
        dec_next.side.sd_v2  = (ver == CSD_SD_V2);
        dec_next.side.r2w    = r2w;
        dec_next.side.bl_len = bl_len;

        blk_shift = {2'd0, mult} + 5'd2 + {1'b0, bl_len - BL_LEN_MIN};
        if (ver == CSD_SD_V2)
        begin
            dec_next.side.blocks = ({11'd0, c_size_v2} + 33'd1) << 10;
        end
        else
        begin
            dec_next.side.blocks = ({21'd0, c_size_v1} + 33'd1) << blk_shift;
        end

        rate_raw = rate_hz(rv, ru);
        if (rate_raw > {3'd0, max_rate})
        begin
            dec_next.side.rate = max_rate;
        end
        else
        begin
            dec_next.side.rate = rate_raw[RATE_W-1:0];
        end

        div80_prod = {24'd0, bus_clock[BUS_W-1:4]} * {23'd0, DIV80_RECIP};
        dec_next.side.bus_div80 = div80_prod[DIV80_SHIFT +: DIV80_W];

        dec_next.x    = {7'd0, bus_clock} * {27'd0, time_value_x10(tv)};
        dec_next.tu   = csd_high[50:48];
        dec_next.nsac = csd_high[47:40];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec = dec_reg;

endmodule

>>> rtl/sdcsd_wait.sv
module sdcsd_wait (
    input  logic             clk,
    input  logic             adv,
    input  sdcsd_pkg::dec_t  dec,
    output sdcsd_pkg::wait_t wt
);
    import sdcsd_pkg::*;

    typedef struct packed {
        side_t            side;
        logic [X_W-1:0]   x;
        logic [2:0]       tu;
        logic [7:0]       nsac;
        logic [Q_W-1:0]   q0;
    } quot_t;

    typedef struct packed {
        side_t                 side;
        logic [X_W-1:0]        x;
        logic [2:0]            tu;
        logic [NSAC_X_W-1:0]   nsac_x100;
        logic [Q_W-1:0]        q0;
        logic [X_W-1:0]        qd;
    } back_t;

    logic [58:0]  recip_prod;
    logic [47:0]  pow5_prod;
    logic [47:0]  qd_wide;
    logic [X_W-1:0] rem;
    logic [Q_W-1:0] q;
    quot_t        quot_next;
    quot_t        quot_reg;
    back_t        back_next;
    back_t        back_reg;
    wait_t        wt_next;
    wait_t        wt_reg;

    always_comb
    begin
        recip_prod       = {25'd0, dec.x} * {34'd0, access_recip(dec.tu)};
        quot_next.side   = dec.side;
        quot_next.x      = dec.x;
        quot_next.tu     = dec.tu;
        quot_next.nsac   = dec.nsac;
        quot_next.q0     = recip_prod[RECIP_SHIFT +: Q_W];
    end

    always_comb
    begin
        pow5_prod           = {24'd0, quot_reg.q0} * {24'd0, access_pow5(quot_reg.tu)};
        qd_wide             = pow5_prod << access_shift(quot_reg.tu);
        back_next.side      = quot_reg.side;
        back_next.x         = quot_reg.x;
        back_next.tu        = quot_reg.tu;
        back_next.nsac_x100 = 15'({7'd0, quot_reg.nsac} * 15'd100);
        back_next.q0        = quot_reg.q0;
        back_next.qd        = qd_wide[X_W-1:0];
    end

    always_comb
    begin
        rem = back_reg.x - back_reg.qd;
        q   = back_reg.q0 + {{(Q_W-1){1'b0}}, (rem >= access_div(back_reg.tu))};
        wt_next.side = back_reg.side;
        wt_next.sum  = q + {{(SUM_W-NSAC_X_W){1'b0}}, back_reg.nsac_x100};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            quot_reg <= quot_next;
            back_reg <= back_next;
            wt_reg   <= wt_next;
        end
    end

    assign wt = wt_reg;

endmodule

>>> tb/sd_csd_metrics_decoder_unit_test.sv
`timescale 1ns / 100ps

module sd_csd_metrics_decoder_unit_test;
    import sdcsd_pkg::*;

    localparam int  LATENCY     = 5;
    localparam int  IDLE_LIMIT  = 4000;
    localparam int  PHASE_ITEMS = 96;
    localparam int  PHASES      = 5;
    localparam int  N_PROBES    = 20;
    localparam logic [BUS_W-1:0] HZ_MAX = 27'd100000000;

    typedef struct packed {
        logic              status;
        logic [SIZE_W-1:0] block_size;
        logic [BLK_W-1:0]  block_count;
        logic [WAIT_W-1:0] read_wait;
        logic [WAIT_W-1:0] write_wait;
        logic [WAIT_W-1:0] erase_wait;
        logic [RATE_W-1:0] bit_rate;
    } metrics_t;

    typedef struct packed {
        logic        fill;
        csd_ver_t    ver;
        logic [3:0]  tv;
        logic [2:0]  tu;
        logic [7:0]  nsac;
        logic [3:0]  rv;
        logic [2:0]  ru;
        logic [3:0]  bl;
        logic        part;
        logic [2:0]  r2w;
        logic [21:0] csize;
        logic [2:0]  mult;
        logic        typed;
        metrics_t    want;
    } probe_row_t;

    localparam metrics_t NO_TYPED = '0;
    localparam metrics_t UNUSABLE = '{status: 1'b1, default: '0};
    localparam metrics_t V2_FULL  = '{status: 1'b0, block_size: 16'd512,
                                      block_count: 33'h1_0000_0000,
                                      read_wait: 40'd150000, write_wait: 40'd375000,
                                      erase_wait: 40'd375000, bit_rate: 27'd16500000};
    localparam metrics_t V1_SLOW  = '{status: 1'b0, block_size: 16'd512,
                                      block_count: 33'd4,
                                      read_wait: 40'd150000, write_wait: 40'd150000,
                                      erase_wait: 40'd150000, bit_rate: 27'd0};

    logic clk;
    logic rst_n;

    sdcsd_cfg_if cfg_bus ();
    sdcsd_in_if  csd_bus ();
    sdcsd_out_if met_bus ();

    sd_csd_metrics_decoder_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .csd     (csd_bus),
        .metrics (met_bus)
    );

    logic [BUS_W-1:0]  bus_hz   = BUS_CLOCK_RESET;
    logic [RATE_W-1:0] rate_cap = MAX_RATE_RESET;
    metrics_t          expected_metrics [$];
    bit                calm = 1'b0;
    int                fails = 0;
    int                words_sent = 0;
    int                usable_seen = 0;
    int                unusable_seen = 0;
    int                idle_cycles = 0;

    // fields: fill, ver, tv, tu, nsac, rv, ru, bl, part, r2w, csize, mult, typed, want
    probe_row_t probe_tab [0:N_PROBES-1] = '{
        '{1'b0, CSD_SD_V1,    4'h0, 3'd0, 8'h00, 4'h0, 3'd0, 4'd0,  1'b0, 3'd0, 22'h0,
          3'd0, 1'b1, UNUSABLE},
        '{1'b1, CSD_RESERVED, 4'hF, 3'd7, 8'hFF, 4'hF, 3'd7, 4'd15, 1'b1, 3'd7, 22'h3FFFFF,
          3'd7, 1'b1, UNUSABLE},
        '{1'b0, CSD_SD_V1,    4'h9, 3'd3, 8'h10, 4'h6, 3'd2, 4'd8,  1'b1, 3'd2, 22'h100,
          3'd2, 1'b1, UNUSABLE},
        '{1'b0, CSD_MMC,      4'h4, 3'd1, 8'h20, 4'h3, 3'd1, 4'd10, 1'b0, 3'd1, 22'h200,
          3'd1, 1'b1, UNUSABLE},
        '{1'b0, CSD_SD_V2,    4'h2, 3'd2, 8'h00, 4'h2, 3'd0, 4'd15, 1'b0, 3'd0, 22'h300,
          3'd0, 1'b1, UNUSABLE},
        '{1'b0, CSD_SD_V1,    4'h5, 3'd4, 8'h01, 4'h5, 3'd2, 4'd9,  1'b0, 3'd6, 22'h010,
          3'd4, 1'b1, UNUSABLE},
        '{1'b0, CSD_SD_V1,    4'h5, 3'd4, 8'h01, 4'h5, 3'd2, 4'd9,  1'b1, 3'd7, 22'h010,
          3'd4, 1'b1, UNUSABLE},
        '{1'b0, CSD_RESERVED, 4'h7, 3'd5, 8'h02, 4'h7, 3'd1, 4'd9,  1'b0, 3'd0, 22'h020,
          3'd1, 1'b1, UNUSABLE},
        '{1'b0, CSD_SD_V1,    4'h7, 3'd5, 8'h02, 4'h7, 3'd4, 4'd9,  1'b0, 3'd0, 22'h020,
          3'd1, 1'b1, UNUSABLE},
        '{1'b0, CSD_SD_V2,    4'h7, 3'd5, 8'h02, 4'h7, 3'd7, 4'd9,  1'b0, 3'd0, 22'h020,
          3'd1, 1'b1, UNUSABLE},
        '{1'b0, CSD_SD_V2,    4'h0, 3'd0, 8'h00, 4'h6, 3'd2, 4'd9,  1'b0, 3'd0, 22'h3FFFFF,
          3'd0, 1'b1, V2_FULL},
        '{1'b0, CSD_SD_V1,    4'h0, 3'd0, 8'h00, 4'h0, 3'd0, 4'd9,  1'b0, 3'd0, 22'h0,
          3'd0, 1'b1, V1_SLOW},
        '{1'b0, CSD_MMC,      4'hF, 3'd7, 8'hFF, 4'hF, 3'd3, 4'd15, 1'b1, 3'd7, 22'hFFF,
          3'd7, 1'b0, NO_TYPED},
        '{1'b0, CSD_SD_V1,    4'hF, 3'd6, 8'hFF, 4'h1, 3'd0, 4'd10, 1'b1, 3'd5, 22'h800,
          3'd3, 1'b0, NO_TYPED},
        '{1'b0, CSD_SD_V1,    4'h1, 3'd0, 8'h01, 4'h2, 3'd1, 4'd9,  1'b0, 3'd1, 22'hFFF,
          3'd7, 1'b0, NO_TYPED},
        '{1'b0, CSD_SD_V2,    4'h3, 3'd2, 8'h00, 4'hF, 3'd3, 4'd9,  1'b1, 3'd0, 22'h0,
          3'd0, 1'b0, NO_TYPED},
        '{1'b0, CSD_MMC,      4'h8, 3'd3, 8'h00, 4'h9, 3'd2, 4'd11, 1'b1, 3'd3, 22'h5A5,
          3'd4, 1'b0, NO_TYPED},
        '{1'b0, CSD_SD_V1,    4'h5, 3'd5, 8'h50, 4'hB, 3'd3, 4'd12, 1'b1, 3'd4, 22'hABC,
          3'd5, 1'b0, NO_TYPED},
        '{1'b1, CSD_SD_V2,    4'hA, 3'd4, 8'h37, 4'h4, 3'd1, 4'd9,  1'b1, 3'd2, 22'h1234,
          3'd0, 1'b0, NO_TYPED},
        '{1'b1, CSD_MMC,      4'h0, 3'd7, 8'h00, 4'h0, 3'd0, 4'd9,  1'b1, 3'd0, 22'h0,
          3'd0, 1'b0, NO_TYPED}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned tenths(input logic [3:0] code);
        case (code)
            4'd0:    return 0;
            4'd1:    return 10;
            4'd2:    return 12;
            4'd3:    return 13;
            4'd4:    return 15;
            4'd5:    return 20;
            4'd6:    return 25;
            4'd7:    return 30;
            4'd8:    return 35;
            4'd9:    return 40;
            4'd10:   return 45;
            4'd11:   return 50;
            4'd12:   return 55;
            4'd13:   return 60;
            4'd14:   return 70;
            default: return 80;
        endcase
    endfunction

    function automatic longint unsigned taac_divisor(input logic [2:0] tu);
        case (tu)
            3'd0:    return 1000000000;
            3'd1:    return 100000000;
            3'd2:    return 10000000;
            3'd3:    return 1000000;
            3'd4:    return 100000;
            3'd5:    return 10000;
            3'd6:    return 1000;
            default: return 100;
        endcase
    endfunction

    function automatic longint unsigned speed_unit(input logic [2:0] ru);
        case (ru)
            3'd0:    return 10000;
            3'd1:    return 100000;
            3'd2:    return 1000000;
            default: return 10000000;
        endcase
    endfunction

    function automatic metrics_t decode_csd(input logic [HIGH_W-1:0] hi,
                                            input logic [MID_W-1:0] mid);
        logic [127:0]      c;
        csd_ver_t          ver;
        logic [3:0]        bl;
        logic [2:0]        r2w;
        logic              bad;
        longint unsigned   bus;
        longint unsigned   blocks;
        longint unsigned   rd;
        longint unsigned   wr;
        longint unsigned   rate;
        metrics_t          m;
        c      = {hi, mid, 8'h00};
        ver    = csd_ver_t'(c[127:126]);
        bl     = c[83:80];
        r2w    = c[28:26];
        bus    = longint'(bus_hz);
        blocks = 0;
        rd     = 0;
        wr     = 0;
        rate   = 0;
        bad    = (bl < 4'd9) || (bl > 4'd9 && !c[79]);
        if (!bad)
        begin
            case (ver)
                CSD_SD_V1, CSD_MMC:
                begin
                    blocks = (longint'(c[73:62]) + 1) << (int'(c[49:47]) + 2);
                    blocks = blocks << (int'(bl) - 9);
                    rd = (bus * tenths(c[118:115])) / 10;
                    rd = rd / taac_divisor(c[114:112]);
                    rd = (rd + longint'(c[111:104]) * 100) / 8 + 1;
                    if (bus / 80 > rd)
                        rd = bus / 80;
                    if (ver == CSD_SD_V1 && r2w > 3'd5)
                        bad = 1'b1;
                    wr = rd << r2w;
                end
                CSD_SD_V2:
                begin
                    blocks = (longint'(c[69:48]) + 1) * 1024;
                    rd = bus / 80;
                    wr = bus / 32;
                end
                default:
                    bad = 1'b1;
            endcase
        end
        if (!bad)
        begin
            if (c[98:96] > 3'd3)
                bad = 1'b1;
            else
            begin
                rate = tenths(c[102:99]) * speed_unit(c[98:96]);
                if (rate > longint'(rate_cap))
                    rate = longint'(rate_cap);
            end
        end
        m = '0;
        if (bad)
            m.status = 1'b1;
        else
        begin
            m.block_size  = SIZE_W'(longint'(1) << bl);
            m.block_count = BLK_W'(blocks);
            m.read_wait   = WAIT_W'(rd);
            m.write_wait  = WAIT_W'(wr);
            m.erase_wait  = WAIT_W'(wr);
            m.bit_rate    = RATE_W'(rate);
        end
        return m;
    endfunction

    function automatic logic [127:0] pack_probe(input probe_row_t p);
        logic [127:0] c;
        c = {128{p.fill}};
        c[127:126] = p.ver;
        c[118:115] = p.tv;
        c[114:112] = p.tu;
        c[111:104] = p.nsac;
        c[102:99]  = p.rv;
        c[98:96]   = p.ru;
        c[83:80]   = p.bl;
        c[79]      = p.part;
        c[28:26]   = p.r2w;
        if (p.ver == CSD_SD_V2)
            c[69:48] = p.csize;
        else
        begin
            c[73:62] = p.csize[11:0];
            c[49:47] = p.mult;
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic push_csd(input logic [HIGH_W-1:0] hi, input logic [MID_W-1:0] mid,
                            input bit typed, input metrics_t want);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            csd_bus.valid = 1'b0;
        end
        @(negedge clk);
        csd_bus.valid    = 1'b1;
        csd_bus.csd_high = hi;
        csd_bus.csd_mid  = mid;
        do
            @(posedge clk);
        while (!csd_bus.ready);
        expected_metrics.push_back(typed ? want : decode_csd(hi, mid));
        words_sent++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            CFG_BUS_CLOCK: bus_hz   = val;
            CFG_MAX_RATE:  rate_cap = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        csd_bus.valid = 1'b0;
        while (expected_metrics.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // mostly well-formed words with random content; the rest raw noise
    task automatic run_random(input int count);
        logic [127:0] c;
        csd_ver_t     ver;
        logic [3:0]   bl;
        for (int i = 0; i < count; i++)
        begin
            c = {$urandom, $urandom, $urandom, $urandom};
            if ($urandom_range(0, 99) < 80)
            begin
                ver        = csd_ver_t'($urandom_range(0, 2));
                bl         = 4'($urandom_range(9, 15));
                c[127:126] = ver;
                c[83:80]   = bl;
                if (bl > 4'd9)
                    c[79] = 1'b1;
                c[98:96] = 3'($urandom_range(0, 3));
                if (ver == CSD_SD_V1)
                    c[28:26] = 3'($urandom_range(0, 5));
            end
            push_csd(c[127:64], c[63:8], 1'b0, NO_TYPED);
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want_v,
                               input longint unsigned got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fails++;
        end
    endtask

    initial
    begin
        int run;
        run = 0;
        met_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run > 0)
            begin
                met_bus.ready = 1'b0;
                run--;
            end
            else
            begin
                met_bus.ready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    run = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        metrics_t got;
        metrics_t want;
        if (rst_n && met_bus.valid && met_bus.ready)
        begin
            got = '{met_bus.status, met_bus.block_size_bytes, met_bus.block_count,
                    met_bus.read_timeout_cycles, met_bus.write_timeout_cycles,
                    met_bus.erase_timeout_cycles, met_bus.bit_rate_hz};
            if (got.status)
                unusable_seen++;
            else
                usable_seen++;
            if (expected_metrics.size() == 0)
            begin
                $error("metrics word with nothing outstanding");
                fails++;
            end
            else
            begin
                want = expected_metrics.pop_front();
                check_field("status", want.status, got.status);
                check_field("block_size_bytes", want.block_size, got.block_size);
                check_field("block_count", want.block_count, got.block_count);
                check_field("read_timeout_cycles", want.read_wait, got.read_wait);
                check_field("write_timeout_cycles", want.write_wait, got.write_wait);
                check_field("erase_timeout_cycles", want.erase_wait, got.erase_wait);
                check_field("bit_rate_hz", want.bit_rate, got.bit_rate);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((csd_bus.valid && csd_bus.ready) || (met_bus.valid && met_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        logic [127:0] c;
        rst_n            = 1'b0;
        csd_bus.valid    = 1'b0;
        csd_bus.csd_high = '0;
        csd_bus.csd_mid  = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = CFG_BUS_CLOCK;
        cfg_bus.data     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_PROBES; i++)
        begin
            c = pack_probe(probe_tab[i]);
            push_csd(c[127:64], c[63:8], probe_tab[i].typed, probe_tab[i].want);
        end
        run_random(PHASE_ITEMS);

        for (int phase = 1; phase < PHASES; phase++)
        begin
            wait_idle();
            calm = (phase == 2);
            case (phase)
                1:
                begin
                    write_reg(CFG_BUS_CLOCK, 27'd1);
                    write_reg(CFG_MAX_RATE, 27'd1);
                end
                2:
                begin
                    write_reg(CFG_BUS_CLOCK, HZ_MAX);
                    write_reg(CFG_MAX_RATE, HZ_MAX);
                end
                3:
                begin
                    write_reg(CFG_BUS_CLOCK, HZ_MAX);
                    write_reg(CFG_MAX_RATE, 27'd1);
                end
                default:
                begin
                    write_reg(CFG_BUS_CLOCK, 27'($urandom_range(1, HZ_MAX)));
                    write_reg(CFG_MAX_RATE, 27'($urandom_range(1, HZ_MAX)));
                end
            endcase
            run_random(PHASE_ITEMS);
        end
        wait_idle();

        if (expected_metrics.size() != 0)
        begin
            $error("%0d metrics words never arrived", expected_metrics.size());
            fails++;
        end
        $display("Sent %0d CSD words across %0d register settings", words_sent, PHASES);
        $display("Checked %0d usable and %0d unusable decodes", usable_seen, unusable_seen);
        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sdcsd_pkg.sv
rtl/sdcsd_ifs.sv
rtl/sdcsd_decode.sv
rtl/sdcsd_wait.sv
rtl/sd_csd_metrics_decoder_unit.sv
tb/sd_csd_metrics_decoder_unit_test.sv
